/* hw/rtl/rhps_pkg.sv */
// Shared types, constants and helpers of the rolling-hash pattern search block.
package rhps_pkg;

   localparam int MAX_PATTERN_DEF = 16;
   localparam int MAX_LINE_DEF    = 4096;
   localparam int RADIX           = 256;

   localparam int BYTE_W     = $clog2(RADIX);
   localparam int BIT_IDX_W  = $clog2(BYTE_W);
   localparam int MOD_W      = 12;
   localparam int HASH_W     = MOD_W;
   localparam int PLEN_W     = 5;
   localparam int PAT_W      = 64;
   localparam int PAT_BYTES  = 2 * PAT_W / BYTE_W;
   localparam int CSR_W      = 64;
   localparam int CSR_IDX_W  = 2;
   localparam int MIDX_W     = 12;
   localparam int LINE_W     = 16;
   localparam int PROD_W     = BYTE_W + MOD_W;
   localparam int CNT_W      = $clog2(PROD_W);

   localparam logic [MOD_W-1:0]  MOD_RESET    = 12'd1987;
   localparam logic [MOD_W-1:0]  MOD_MIN      = 12'd2;
   localparam logic [PLEN_W-1:0] PLEN_RESET   = 5'd1;
   localparam logic [LINE_W-1:0] LINE_CNT_MAX = 16'hFFFF;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODULUS = 2'd0,
      CSR_PLEN    = 2'd1,
      CSR_PAT_LO  = 2'd2,
      CSR_PAT_HI  = 2'd3
   } csr_idx_type;

   typedef enum logic [2:0] {
      UOP_NONE   = 3'd0,
      UOP_LOAD   = 3'd1,
      UOP_SHIFT  = 3'd2,
      UOP_SUBMOD = 3'd3,
      UOP_MUL    = 3'd4
   } uop_type;

   typedef struct packed {
      uop_type           op;
      logic              shift_bit;
      logic [MOD_W-1:0]  value;
      logic [BYTE_W-1:0] opnd_byte;
   } unit_cmd_type;

   typedef struct packed {
      logic [MOD_W-1:0]   modulus;
      logic [PLEN_W-1:0]  pattern_length;
      logic [2*PAT_W-1:0] pattern;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] text_byte;
      logic              byte_valid;
      logic              last_in_line;
   } item_type;

   typedef struct packed {
      logic              push;
      logic [MIDX_W-1:0] match_index;
      logic [LINE_W-1:0] line_number;
      logic [HASH_W-1:0] window_hash;
   } res_type;

   function automatic logic [BYTE_W-1:0] pat_byte(input logic [2*PAT_W-1:0] pat,
                                                  input logic [31:0] j);
      if (j < 32'(PAT_BYTES)) begin
         return pat[j*BYTE_W +: BYTE_W];
      end
      return '0;
   endfunction

endpackage

/* hw/rtl/rhps_if.sv */
// Request and response channel interfaces of the rolling-hash pattern search block.
interface rhps_req_if import rhps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] text_byte;
   logic              byte_valid;
   logic              last_in_line;

   modport source (output valid, output text_byte, output byte_valid, output last_in_line,
                   input ready);
   modport sink   (input valid, input text_byte, input byte_valid, input last_in_line,
                   output ready);
endinterface

interface rhps_rsp_if import rhps_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [MIDX_W-1:0] match_index;
   logic [LINE_W-1:0] line_number;
   logic [HASH_W-1:0] window_hash;

   modport source (output valid, output match_index, output line_number, output window_hash,
                   input ready);
   modport sink   (input valid, input match_index, input line_number, input window_hash,
                   output ready);
endinterface

/* hw/rtl/rhps_modunit.sv */
// Shared modular arithmetic unit: load, shift-in-and-reduce, modular subtract, multiply.
module rhps_modunit import rhps_pkg::*; (
   input  logic               clock,
   input  unit_cmd_type       ucmd,
   input  logic [MOD_W-1:0]   umod,
   output logic [MOD_W-1:0]   uacc,
   output logic [PROD_W-1:0]  uprod
);

   logic [MOD_W-1:0]  acc_ff;
   logic [MOD_W-1:0]  acc_in;
   logic [PROD_W-1:0] prod_ff;
   logic [PROD_W-1:0] prod_in;
   logic [MOD_W:0]    shifted;
   logic [MOD_W:0]    diff;

   always_comb begin
      acc_in  = acc_ff;
      prod_in = prod_ff;
      shifted = {acc_ff, ucmd.shift_bit};
      diff    = {1'b0, ucmd.value} - {1'b0, acc_ff};
      case (ucmd.op)
         UOP_LOAD: begin
            acc_in = ucmd.value;
         end
         UOP_SHIFT: begin
            if (shifted >= {1'b0, umod}) begin
               acc_in = MOD_W'(shifted - {1'b0, umod});
            end else begin
               acc_in = MOD_W'(shifted);
            end
         end
         UOP_SUBMOD: begin
            if (diff[MOD_W]) begin
               acc_in = MOD_W'(diff + {1'b0, umod});
            end else begin
               acc_in = MOD_W'(diff);
            end
         end
         UOP_MUL: begin
            prod_in = PROD_W'(ucmd.opnd_byte) * PROD_W'(ucmd.value);
         end
         default: begin
            acc_in = acc_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
   end

   assign uacc  = acc_ff;
   assign uprod = prod_ff;

endmodule

/* hw/rtl/rhps_ctrl.sv */
// Sequencer, line state and window ring of the rolling-hash pattern search block.
module rhps_ctrl import rhps_pkg::*; #(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int MAX_LINE    = MAX_LINE_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               item_take,
   input  item_type           item,
   output logic               item_ready,
   input  logic               rsp_busy,
   output res_type            res,
   output unit_cmd_type       ucmd,
   output logic [MOD_W-1:0]   umod,
   input  logic [MOD_W-1:0]   uacc,
   input  logic [PROD_W-1:0]  uprod
);

   localparam int IDX_W  = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int RING_W = IDX_W + 1;
   localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
   localparam int POS_W  = $clog2(MAX_LINE + 1);
   localparam logic [IDX_W-1:0]  IDX_LAST = IDX_W'(MAX_PATTERN - 1);
   localparam logic [RING_W-1:0] RING_P   = RING_W'(MAX_PATTERN);
   localparam logic [POS_W-1:0]  POS_LIM  = POS_W'(MAX_LINE);
   localparam logic [CNT_W-1:0]  BIT_LAST = CNT_W'(BYTE_W - 1);
   localparam logic [CNT_W-1:0]  PROD_LAST = CNT_W'(PROD_W - 1);

   typedef enum logic [12:0] {
      ST_IDLE  = 13'h0001,
      ST_POW   = 13'h0002,
      ST_PHASH = 13'h0004,
      ST_BYTE  = 13'h0008,
      ST_MUL   = 13'h0010,
      ST_CLR   = 13'h0020,
      ST_RED   = 13'h0040,
      ST_SUB   = 13'h0080,
      ST_ADD   = 13'h0100,
      ST_UPD   = 13'h0200,
      ST_CRD   = 13'h0400,
      ST_CCMP  = 13'h0800,
      ST_DONE  = 13'h1000
   } state_type;

   state_type          state_ff, state_in;
   logic               line_open_ff, line_open_in;
   logic               match_ff, match_in;
   logic [MOD_W-1:0]   cur_mod_ff, cur_mod_in;
   logic [LEN_W-1:0]   cur_len_ff, cur_len_in;
   logic [HASH_W-1:0]  lp_ff, lp_in;
   logic [HASH_W-1:0]  ph_ff, ph_in;
   logic [HASH_W-1:0]  hash_ff, hash_in;
   logic [POS_W-1:0]   pos_ff, pos_in;
   logic [LINE_W-1:0]  line_cnt_ff, line_cnt_in;
   item_type           item_ff, item_in;
   logic [IDX_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]   cmp_idx_ff, cmp_idx_in;
   logic [LEN_W-1:0]   j_ff, j_in;
   logic [CNT_W-1:0]   bit_ff, bit_in;
   logic [MIDX_W-1:0]  mstart_ff, mstart_in;
   logic [BYTE_W-1:0]  win_rd_ff;
   logic [BYTE_W-1:0]  window_mem [MAX_PATTERN];

   logic               win_we;
   logic [IDX_W-1:0]   win_raddr;
   logic [RING_W-1:0]  ring_old;
   logic [RING_W-1:0]  ring_start;
   logic [IDX_W-1:0]   old_idx;
   logic [IDX_W-1:0]   start_idx;
   logic [IDX_W-1:0]   wr_next;
   logic [IDX_W-1:0]   cmp_next;
   logic [BYTE_W-1:0]  pat_cur;
   logic [BIT_IDX_W-1:0] bit_sel;
   logic               pos_ge_len;
   logic               full_window;
   logic               byte_done;

   always_comb begin
      ring_old    = RING_W'(wr_ptr_ff) + RING_P - RING_W'(cur_len_ff);
      ring_start  = ring_old + 1'b1;
      old_idx     = (ring_old >= RING_P) ? IDX_W'(ring_old - RING_P) : IDX_W'(ring_old);
      start_idx   = (ring_start >= RING_P) ? IDX_W'(ring_start - RING_P) : IDX_W'(ring_start);
      wr_next     = (wr_ptr_ff == IDX_LAST) ? '0 : wr_ptr_ff + 1'b1;
      cmp_next    = (cmp_idx_ff == IDX_LAST) ? '0 : cmp_idx_ff + 1'b1;
      pat_cur     = pat_byte(cfg.pattern, 32'(j_ff));
      bit_sel     = BIT_IDX_W'(BIT_LAST - bit_ff);
      pos_ge_len  = 32'(pos_ff) >= 32'(cur_len_ff);
      full_window = (32'(pos_ff) + 32'd1) >= 32'(cur_len_ff);
      byte_done   = (bit_ff == BIT_LAST);
   end

   always_comb begin
      state_in     = state_ff;
      line_open_in = line_open_ff;
      match_in     = match_ff;
      cur_mod_in   = cur_mod_ff;
      cur_len_in   = cur_len_ff;
      lp_in        = lp_ff;
      ph_in        = ph_ff;
      hash_in      = hash_ff;
      pos_in       = pos_ff;
      line_cnt_in  = line_cnt_ff;
      item_in      = item_ff;
      wr_ptr_in    = wr_ptr_ff;
      cmp_idx_in   = cmp_idx_ff;
      j_in         = j_ff;
      bit_in       = bit_ff;
      mstart_in    = mstart_ff;
      win_we       = 1'b0;
      win_raddr    = cmp_idx_ff;
      ucmd         = '{op: UOP_NONE, shift_bit: 1'b0, value: '0, opnd_byte: '0};
      res.push        = 1'b0;
      res.match_index = mstart_ff;
      res.line_number = line_cnt_ff;
      res.window_hash = hash_ff;

      case (state_ff)
         ST_IDLE: begin
            if (item_take) begin
               item_in = item;
               if (!line_open_ff) begin
                  cur_mod_in = (cfg.modulus < MOD_MIN) ? MOD_MIN : cfg.modulus;
                  if (cfg.pattern_length == '0) begin
                     cur_len_in = LEN_W'(1);
                  end else if (32'(cfg.pattern_length) > 32'(MAX_PATTERN)) begin
                     cur_len_in = LEN_W'(MAX_PATTERN);
                  end else begin
                     cur_len_in = LEN_W'(cfg.pattern_length);
                  end
                  if (line_cnt_ff != LINE_CNT_MAX) begin
                     line_cnt_in = line_cnt_ff + 1'b1;
                  end
                  pos_in       = '0;
                  hash_in      = '0;
                  wr_ptr_in    = '0;
                  line_open_in = 1'b1;
                  ucmd.op      = UOP_LOAD;
                  ucmd.value   = MOD_W'(1);
                  j_in         = LEN_W'(1);
                  bit_in       = '0;
                  state_in     = ST_POW;
               end else begin
                  state_in = ST_BYTE;
               end
            end
         end
         ST_POW: begin
            if (j_ff >= cur_len_ff) begin
               lp_in      = uacc;
               ucmd.op    = UOP_LOAD;
               ucmd.value = '0;
               j_in       = '0;
               bit_in     = '0;
               state_in   = ST_PHASH;
            end else begin
               ucmd.op        = UOP_SHIFT;
               ucmd.shift_bit = 1'b0;
               if (byte_done) begin
                  bit_in = '0;
                  j_in   = j_ff + 1'b1;
               end else begin
                  bit_in = bit_ff + 1'b1;
               end
            end
         end
         ST_PHASH: begin
            if (j_ff >= cur_len_ff) begin
               ph_in    = uacc;
               state_in = ST_BYTE;
            end else begin
               ucmd.op        = UOP_SHIFT;
               ucmd.shift_bit = pat_cur[bit_sel];
               if (byte_done) begin
                  bit_in = '0;
                  j_in   = j_ff + 1'b1;
               end else begin
                  bit_in = bit_ff + 1'b1;
               end
            end
         end
         ST_BYTE: begin
            if (item_ff.byte_valid && (pos_ff < POS_LIM)) begin
               if (pos_ge_len) begin
                  win_raddr = old_idx;
                  state_in  = ST_MUL;
               end else begin
                  ucmd.op    = UOP_LOAD;
                  ucmd.value = hash_ff;
                  bit_in     = '0;
                  state_in   = ST_ADD;
               end
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_MUL: begin
            ucmd.op        = UOP_MUL;
            ucmd.value     = lp_ff;
            ucmd.opnd_byte = win_rd_ff;
            state_in       = ST_CLR;
         end
         ST_CLR: begin
            ucmd.op    = UOP_LOAD;
            ucmd.value = '0;
            bit_in     = '0;
            state_in   = ST_RED;
         end
         ST_RED: begin
            ucmd.op        = UOP_SHIFT;
            ucmd.shift_bit = uprod[PROD_LAST - bit_ff];
            if (bit_ff == PROD_LAST) begin
               bit_in   = '0;
               state_in = ST_SUB;
            end else begin
               bit_in = bit_ff + 1'b1;
            end
         end
         ST_SUB: begin
            ucmd.op    = UOP_SUBMOD;
            ucmd.value = hash_ff;
            bit_in     = '0;
            state_in   = ST_ADD;
         end
         ST_ADD: begin
            ucmd.op        = UOP_SHIFT;
            ucmd.shift_bit = item_ff.text_byte[bit_sel];
            if (byte_done) begin
               bit_in   = '0;
               state_in = ST_UPD;
            end else begin
               bit_in = bit_ff + 1'b1;
            end
         end
         ST_UPD: begin
            hash_in   = uacc;
            win_we    = 1'b1;
            wr_ptr_in = wr_next;
            pos_in    = pos_ff + 1'b1;
            if (full_window && (uacc == ph_ff)) begin
               mstart_in  = MIDX_W'(32'(pos_ff) + 32'd1 - 32'(cur_len_ff));
               cmp_idx_in = start_idx;
               j_in       = '0;
               state_in   = ST_CRD;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_CRD: begin
            if (j_ff >= cur_len_ff) begin
               match_in = 1'b1;
               state_in = ST_DONE;
            end else begin
               win_raddr = cmp_idx_ff;
               state_in  = ST_CCMP;
            end
         end
         ST_CCMP: begin
            if (win_rd_ff != pat_cur) begin
               state_in = ST_DONE;
            end else begin
               j_in       = j_ff + 1'b1;
               cmp_idx_in = cmp_next;
               state_in   = ST_CRD;
            end
         end
         ST_DONE: begin
            if (!(match_ff && rsp_busy)) begin
               res.push = match_ff;
               match_in = 1'b0;
               if (item_ff.last_in_line) begin
                  line_open_in = 1'b0;
                  pos_in       = '0;
               end
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         line_open_ff <= 1'b0;
         match_ff     <= 1'b0;
         cur_mod_ff   <= MOD_RESET;
         cur_len_ff   <= LEN_W'(1);
         lp_ff        <= HASH_W'(1);
         ph_ff        <= '0;
         hash_ff      <= '0;
         pos_ff       <= '0;
         line_cnt_ff  <= '0;
      end else begin
         state_ff     <= state_in;
         line_open_ff <= line_open_in;
         match_ff     <= match_in;
         cur_mod_ff   <= cur_mod_in;
         cur_len_ff   <= cur_len_in;
         lp_ff        <= lp_in;
         ph_ff        <= ph_in;
         hash_ff      <= hash_in;
         pos_ff       <= pos_in;
         line_cnt_ff  <= line_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff    <= item_in;
      wr_ptr_ff  <= wr_ptr_in;
      cmp_idx_ff <= cmp_idx_in;
      j_ff       <= j_in;
      bit_ff     <= bit_in;
      mstart_ff  <= mstart_in;
   end

   always_ff @(posedge clock) begin
      if (win_we) begin
         window_mem[wr_ptr_ff] <= item_ff.text_byte;
      end
      win_rd_ff <= window_mem[win_raddr];
   end

   assign item_ready = (state_ff == ST_IDLE);
   assign umod       = cur_mod_ff;

endmodule

/* hw/rtl/rolling_hash_pattern_search.sv */
// Top level of the rolling-hash pattern search block: config registers and result register.
//
//  channel   | direction | handshake        | payload
//  ----------+-----------+------------------+---------------------------------------------
//  req_chan  | in        | valid / ready    | text_byte, byte_valid, last_in_line
//  rsp_chan  | out       | valid / ready    | match_index, line_number, window_hash
//  csr_*     | in        | csr_wr_en only   | csr_index, csr_wdata
//
//  One request at a time. A byte with a full window runs the 20-step product reduction
//  and then the 8-step byte fold in the shared modular unit, a byte before the window
//  fills only the byte fold, a marker without a byte neither. A hash hit adds a window
//  compare; the first request of a line also computes the leading power and pattern hash.
//  Reset is synchronous; no clearing pass. A waiting result holds; the next request is
//  still taken, and only a second result stalls until the first is taken.
module rolling_hash_pattern_search import rhps_pkg::*; #(
   parameter int MAX_PATTERN = MAX_PATTERN_DEF,
   parameter int MAX_LINE    = MAX_LINE_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   rhps_req_if.sink              req_chan,
   rhps_rsp_if.source            rsp_chan,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_W-1:0]      csr_wdata
);

   logic [MOD_W-1:0]   modulus_ff, modulus_in;
   logic [PLEN_W-1:0]  plen_ff, plen_in;
   logic [PAT_W-1:0]   pat_lo_ff, pat_lo_in;
   logic [PAT_W-1:0]   pat_hi_ff, pat_hi_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [MIDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [LINE_W-1:0]  rsp_line_ff, rsp_line_in;
   logic [HASH_W-1:0]  rsp_hash_ff, rsp_hash_in;

   cfg_type            cfg;
   item_type           item;
   res_type            res;
   unit_cmd_type       ucmd;
   logic               item_ready;
   logic               item_take;
   logic               rsp_busy;
   logic [MOD_W-1:0]   umod;
   logic [MOD_W-1:0]   uacc;
   logic [PROD_W-1:0]  uprod;

   always_comb begin
      modulus_in = modulus_ff;
      plen_in    = plen_ff;
      pat_lo_in  = pat_lo_ff;
      pat_hi_in  = pat_hi_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_MODULUS: modulus_in = csr_wdata[MOD_W-1:0];
            CSR_PLEN:    plen_in    = csr_wdata[PLEN_W-1:0];
            CSR_PAT_LO:  pat_lo_in  = csr_wdata[PAT_W-1:0];
            CSR_PAT_HI:  pat_hi_in  = csr_wdata[PAT_W-1:0];
            default:     modulus_in = modulus_ff;
         endcase
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_idx_in   = rsp_idx_ff;
      rsp_line_in  = rsp_line_ff;
      rsp_hash_in  = rsp_hash_ff;
      if (res.push) begin
         rsp_valid_in = 1'b1;
         rsp_idx_in   = res.match_index;
         rsp_line_in  = res.line_number;
         rsp_hash_in  = res.window_hash;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff   <= MOD_RESET;
         plen_ff      <= PLEN_RESET;
         pat_lo_ff    <= '0;
         pat_hi_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         modulus_ff   <= modulus_in;
         plen_ff      <= plen_in;
         pat_lo_ff    <= pat_lo_in;
         pat_hi_ff    <= pat_hi_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_idx_ff  <= rsp_idx_in;
      rsp_line_ff <= rsp_line_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign cfg.modulus        = modulus_ff;
   assign cfg.pattern_length = plen_ff;
   assign cfg.pattern        = {pat_hi_ff, pat_lo_ff};

   assign item.text_byte    = req_chan.text_byte;
   assign item.byte_valid   = req_chan.byte_valid;
   assign item.last_in_line = req_chan.last_in_line;
   assign item_take         = req_chan.valid & item_ready;
   assign req_chan.ready    = item_ready;

   assign rsp_busy             = rsp_valid_ff & ~rsp_chan.ready;
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_index = rsp_idx_ff;
   assign rsp_chan.line_number = rsp_line_ff;
   assign rsp_chan.window_hash = rsp_hash_ff;

   rhps_ctrl #(
      .MAX_PATTERN (MAX_PATTERN),
      .MAX_LINE    (MAX_LINE)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .item_take  (item_take),
      .item       (item),
      .item_ready (item_ready),
      .rsp_busy   (rsp_busy),
      .res        (res),
      .ucmd       (ucmd),
      .umod       (umod),
      .uacc       (uacc),
      .uprod      (uprod)
   );

   rhps_modunit u_modunit (
      .clock (clock),
      .ucmd  (ucmd),
      .umod  (umod),
      .uacc  (uacc),
      .uprod (uprod)
   );

endmodule

/* hw/rtl/rhps_chk.sv */
// Port-level assertion checker of the rolling-hash pattern search block, with its bind.
module rhps_chk import rhps_pkg::*; (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input logic [MIDX_W-1:0] rsp_match_index,
   input logic [LINE_W-1:0] rsp_line_number,
   input logic [HASH_W-1:0] rsp_window_hash
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_match_index)
         && $stable(rsp_line_number) && $stable(rsp_window_hash))
      else $error("response changed while stalled");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while previous request still in work");

   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_line_number != '0)
      else $error("response carries line number zero");

   a_push_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("response appeared without a request in work");

endmodule

bind rolling_hash_pattern_search rhps_chk u_rhps_chk (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_chan.valid),
   .req_ready       (req_chan.ready),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_match_index (rsp_chan.match_index),
   .rsp_line_number (rsp_chan.line_number),
   .rsp_window_hash (rsp_chan.window_hash)
);

/* test/tb_rolling_hash_pattern_search.sv */
// Testbench of the rolling-hash pattern search block: directed and random text lines.
`timescale 1ns / 1ps

module tb_rolling_hash_pattern_search import rhps_pkg::*; ();

   localparam int RANDOM_ITEMS  = 1100;
   localparam int SETTLE_CYCLES = 400;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic [MIDX_W-1:0] match_index;
      logic [LINE_W-1:0] line_number;
      logic [HASH_W-1:0] window_hash;
   } match_type;

   logic               clock = 1'b0;
   logic               reset;
   logic               csr_wr_en;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0]   csr_wdata;

   rhps_req_if req_chan ();
   rhps_rsp_if rsp_chan ();

   rolling_hash_pattern_search DUT (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // register copies
   int unsigned       cfg_modulus = MOD_RESET;
   int unsigned       cfg_plen    = PLEN_RESET;
   logic [PAT_W-1:0]  cfg_pat_lo  = '0;
   logic [PAT_W-1:0]  cfg_pat_hi  = '0;

   // search state
   int unsigned       roll_hash   = 0;
   logic [7:0]        window_ring [MAX_PATTERN_DEF];
   int unsigned       pat_hash    = 0;
   int unsigned       lead_power  = 1;
   int unsigned       line_pos    = 0;
   int unsigned       line_count  = 0;
   bit                line_open   = 1'b0;
   int unsigned       line_mod    = MOD_RESET;
   int unsigned       line_len    = PLEN_RESET;

   match_type         pending_matches[$];
   match_type         head_match;
   int                error_count     = 0;
   int                random_items    = 0;
   int                req_idle_pct    = 14;
   int                rsp_idle_pct    = 54;
   int                rsp_hold_cycles = 0;

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   function automatic int unsigned pattern_span(input int unsigned n);
      if (n < 1) return 1;
      if (n > MAX_PATTERN_DEF) return MAX_PATTERN_DEF;
      return n;
   endfunction

   function automatic logic [7:0] pattern_byte(input int unsigned j);
      if (j < 8) return cfg_pat_lo[8*j +: 8];
      if (j < 16) return cfg_pat_hi[8*(j-8) +: 8];
      return 8'h00;
   endfunction

   function automatic void open_line();
      int unsigned j;
      line_mod   = (cfg_modulus < 2) ? 2 : cfg_modulus;
      line_len   = pattern_span(cfg_plen);
      lead_power = 1 % line_mod;
      for (j = 1; j < line_len; j++) lead_power = (lead_power * RADIX) % line_mod;
      pat_hash = 0;
      for (j = 0; j < line_len; j++) pat_hash = (pat_hash * RADIX + pattern_byte(j)) % line_mod;
      roll_hash = 0;
      line_pos  = 0;
      if (line_count < 65535) line_count++;
      line_open = 1'b1;
   endfunction

   function automatic void scan_request(input logic [7:0] b, input bit v, input bit l);
      int unsigned h, sub, start, j;
      bit          same;
      match_type   hit;
      if (!line_open) open_line();
      if (v && line_pos < MAX_LINE_DEF) begin
         h = roll_hash;
         if (line_pos >= line_len) begin
            sub = (window_ring[(line_pos - line_len) % MAX_PATTERN_DEF] * lead_power) % line_mod;
            h = (h + line_mod - sub) % line_mod;
         end
         h = (h * RADIX + b) % line_mod;
         roll_hash = h;
         window_ring[line_pos % MAX_PATTERN_DEF] = b;
         line_pos++;
         if (line_pos >= line_len && h == pat_hash) begin
            start = line_pos - line_len;
            same  = 1'b1;
            for (j = 0; j < line_len; j++) begin
               if (window_ring[(start + j) % MAX_PATTERN_DEF] != pattern_byte(j)) same = 1'b0;
            end
            if (same) begin
               hit.match_index = start[MIDX_W-1:0];
               hit.line_number = line_count[LINE_W-1:0];
               hit.window_hash = h[HASH_W-1:0];
               pending_matches.push_back(hit);
            end
         end
      end
      if (l) begin
         line_open = 1'b0;
         line_pos  = 0;
      end
   endfunction

   task automatic send_request(input logic [7:0] b, input bit v, input bit l);
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.text_byte    <= b;
      req_chan.byte_valid   <= v;
      req_chan.last_in_line <= l;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      scan_request(b, v, l);
   endtask

   task automatic send_text(input string s, input bit end_line);
      for (int i = 0; i < s.len(); i++) send_request(s[i], 1'b1, end_line && i == s.len() - 1);
   endtask

   task automatic write_csr(input csr_idx_type idx, input logic [CSR_W-1:0] data);
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_MODULUS: cfg_modulus = data[MOD_W-1:0];
         CSR_PLEN:    cfg_plen    = data[PLEN_W-1:0];
         CSR_PAT_LO:  cfg_pat_lo  = data;
         CSR_PAT_HI:  cfg_pat_hi  = data;
      endcase
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic wait_for_idle();
      @(negedge clock);
      req_chan.valid <= 1'b0;
      while (pending_matches.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic report_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         error_count++;
      end
   endtask

   // response side: random stall, or a long hold when requested
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_chan.ready <= 1'b0;
         end else begin
            rsp_chan.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_matches.size() == 0) begin
            $display("%0t: unexpected match, expected none actual index %0d line %0d hash %0d",
                     $time, rsp_chan.match_index, rsp_chan.line_number, rsp_chan.window_hash);
            error_count++;
         end else begin
            head_match = pending_matches.pop_front();
            report_field("match_index", head_match.match_index, rsp_chan.match_index);
            report_field("line_number", head_match.line_number, rsp_chan.line_number);
            report_field("window_hash", head_match.window_hash, rsp_chan.window_hash);
         end
      end
   end

   task automatic test_reset_defaults();
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b1);
   endtask

   task automatic test_basic_match();
      wait_for_idle();
      write_csr(CSR_MODULUS, 64'd2039);
      write_csr(CSR_PLEN, 64'd4);
      write_csr(CSR_PAT_LO, 64'h4443_4241);
      send_text("xxABCDyABCD", 1'b1);
   endtask

   task automatic test_modulus_floor();
      wait_for_idle();
      write_csr(CSR_MODULUS, 64'd0);
      write_csr(CSR_PLEN, 64'd3);
      write_csr(CSR_PAT_LO, 64'h63_6261);
      send_text("abcxyzabd", 1'b1);
      wait_for_idle();
      write_csr(CSR_MODULUS, 64'd1);
      send_text("zabc", 1'b1);
   endtask

   task automatic test_pattern_lengths();
      wait_for_idle();
      write_csr(CSR_MODULUS, 64'd4095);
      write_csr(CSR_PLEN, 64'd16);
      write_csr(CSR_PAT_LO, 64'h00FF_00FF_00FF_00FF);
      write_csr(CSR_PAT_HI, 64'hFF00_FF00_FF00_FFFF);
      for (int j = 0; j < 16; j++) send_request(pattern_byte(j), 1'b1, j == 15);
      wait_for_idle();
      write_csr(CSR_PLEN, 64'd31);
      send_request(8'h7E, 1'b1, 1'b0);
      for (int j = 0; j < 16; j++) send_request(pattern_byte(j), 1'b1, j == 15);
      wait_for_idle();
      write_csr(CSR_PLEN, 64'd0);
      write_csr(CSR_PAT_LO, 64'h0);
      send_request(8'h00, 1'b1, 1'b0);
      send_request(8'hFF, 1'b1, 1'b0);
      send_request(8'h00, 1'b1, 1'b1);
   endtask

   task automatic test_short_line();
      wait_for_idle();
      write_csr(CSR_MODULUS, 64'd1987);
      write_csr(CSR_PLEN, 64'd8);
      write_csr(CSR_PAT_LO, 64'h4847_4645_4443_4241);
      send_text("ABCDE", 1'b1);
      send_text("ABCDEFGH", 1'b1);
   endtask

   task automatic test_empty_lines();
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'h5A, 1'b0, 1'b0);
      send_text("ABCDEFGH", 1'b0);
      send_request(8'h41, 1'b0, 1'b0);
      send_request(8'h00, 1'b0, 1'b1);
      send_request(8'hFF, 1'b0, 1'b1);
   endtask

   task automatic test_midline_config();
      wait_for_idle();
      write_csr(CSR_MODULUS, 64'd2039);
      write_csr(CSR_PLEN, 64'd2);
      write_csr(CSR_PAT_LO, 64'h4241);
      send_text("ZAB", 1'b0);
      // length, modulus and pattern hash wait for the next line, the byte compare uses new pattern bytes at once
      wait_for_idle();
      write_csr(CSR_PLEN, 64'd3);
      write_csr(CSR_MODULUS, 64'd97);
      write_csr(CSR_PAT_LO, 64'h4341);
      send_text("ABAC", 1'b1);
      send_text("xAC", 1'b0);
      send_request(8'h00, 1'b1, 1'b1);
   endtask

   task automatic test_output_stall();
      wait_for_idle();
      write_csr(CSR_PLEN, 64'd1);
      write_csr(CSR_PAT_LO, 64'h41);
      rsp_hold_cycles = HOLD_CYCLES;
      for (int i = 0; i < 12; i++) send_request(8'h41, 1'b1, i == 11);
   endtask

   task automatic pick_search_config();
      int unsigned sel;
      logic [CSR_W-1:0] m, n;
      sel = $urandom_range(0, 9);
      case (sel)
         0:       m = $urandom_range(0, 1);
         1:       m = 4095;
         2:       m = 2039;
         3:       m = $urandom_range(2, 16);
         default: m = $urandom_range(2, 4095);
      endcase
      sel = $urandom_range(0, 9);
      case (sel)
         0:       n = 0;
         1:       n = 16;
         2:       n = $urandom_range(5, 31);
         default: n = $urandom_range(1, 4);
      endcase
      write_csr(CSR_MODULUS, m);
      write_csr(CSR_PLEN, n);
      write_csr(CSR_PAT_LO, {$urandom, $urandom});
      write_csr(CSR_PAT_HI, {$urandom, $urandom});
   endtask

   task automatic send_random_line();
      int unsigned n, k, j, r, span, copy_len;
      bit          noisy;
      item_type    it;
      item_type    line_items[$];
      span  = pattern_span(cfg_plen);
      noisy = ($urandom_range(0, 99) < 15);
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 40);
      k = 0;
      while (k < n) begin
         r = $urandom_range(0, 99);
         it = '0;
         it.byte_valid = 1'b1;
         if (r < 5) begin
            it.byte_valid = 1'b0;
            it.text_byte  = 8'($urandom);
            line_items.push_back(it);
            k++;
         end else if (!noisy && r < 40) begin
            // whole pattern, or a cut-off copy for a near miss
            copy_len = (r < 12) ? $urandom_range(1, span) : span;
            for (j = 0; j < copy_len; j++) begin
               it.text_byte = pattern_byte(j);
               line_items.push_back(it);
            end
            k += copy_len;
         end else begin
            it.text_byte = (!noisy && r < 70) ? pattern_byte($urandom_range(0, span - 1))
                                              : 8'($urandom);
            line_items.push_back(it);
            k++;
         end
      end
      if (line_items.size() == 0 || $urandom_range(0, 9) == 0) begin
         it = '0;
         it.text_byte    = 8'($urandom);
         it.last_in_line = 1'b1;
         line_items.push_back(it);
      end else begin
         line_items[$].last_in_line = 1'b1;
      end
      foreach (line_items[i])
         send_request(line_items[i].text_byte, line_items[i].byte_valid,
                      line_items[i].last_in_line);
      random_items += line_items.size();
   endtask

   task automatic test_random_text();
      for (int phase = 0; phase < 3; phase++) begin
         req_idle_pct = (phase == 0) ? 14 : (phase == 1) ? 54 : 0;
         rsp_idle_pct = (phase == 0) ? 54 : (phase == 1) ? 14 : 0;
         while (random_items < (phase + 1) * RANDOM_ITEMS / 3) begin
            wait_for_idle();
            pick_search_config();
            repeat ($urandom_range(3, 10)) send_random_line();
         end
      end
   endtask

   initial begin
      reset                 = 1'b1;
      req_chan.valid        = 1'b0;
      req_chan.text_byte    = '0;
      req_chan.byte_valid   = 1'b0;
      req_chan.last_in_line = 1'b0;
      csr_wr_en             = 1'b0;
      csr_index             = CSR_MODULUS;
      csr_wdata             = '0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_basic_match();
      test_modulus_floor();
      test_pattern_lengths();
      test_short_line();
      test_empty_lines();
      test_midline_config();
      test_output_stall();
      test_random_text();

      wait_for_idle();
      if (error_count == 0 && pending_matches.size() == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

   initial begin
      #12_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule
